// File: sv/pre_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the population rate evaluator.
package pre_pkg;

  typedef enum logic [1:0] {
    CMD_STARVE = 2'd0,
    CMD_DEATH  = 2'd1,
    CMD_DUP    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_SAT = 2'd2
  } status_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_STARVE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEATH  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DUP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CAP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COUNT  = 3'd4;

  localparam int unsigned CfgDataW  = 47;
  localparam int unsigned InDataW   = 376;
  localparam int unsigned OutDataW  = 64;
  localparam int unsigned GainBits  = 16;
  localparam logic [8:0]  SpeciesMax = 9'd256;
  localparam logic [62:0] Max63     = {63{1'b1}};

  // fields carried through the front stages
  typedef struct packed {
    cmd_e        cmd;
    logic        bad;
    logic        alive;
    logic        ge2;
    logic        dupok;
    logic [63:0] n;
    logic [63:0] bm;
    logic [63:0] bmean;
    logic [63:0] bmax;
    logic [62:0] eff;
    logic [46:0] left;
  } early_t;

  // per-item control carried along the back stages
  typedef struct packed {
    cmd_e cmd;
    logic bad;
    logic zero;
    logic sat;
    logic nul;
  } tag_t;

endpackage

// File: sv/population_rate_evaluator_top.sv
`timescale 1ns / 1ps
// Population rate evaluator: a pipeline from item to rate.
//
// Items arrive on the s_axis channel (command in tuser, operands in tdata) and
// one result per item leaves on m_axis (rate in tdata, status in tuser).
// Registers are written on the cfg channel, which is always ready; write them
// only while no item is in flight.
// The pipeline has 142 register stages: a 6-stage front end (clamps, cubic
// fade, operand select, 64x64 product), a load register and a 64-stage
// restoring divider that retires one quotient bit per stage, 4 stages of room
// fraction and gain products, a 64x64 product, a second load register and
// 64-stage divider for the soft cap, and the output register. One item is
// taken every cycle while the receiver does not stall; all stages move
// together, so s_axis_tready is high whenever the output register is empty or
// being drained. When the receiver stalls, every stage holds and nothing is
// lost or repeated. Reset clears the configuration registers and all stage
// valid bits; the block is ready in the first cycle after reset.
module population_rate_evaluator_top #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // species[7:0], population_level[71:8], biomass[135:72], biomass_min[199:136],
  // biomass_mean[263:200], biomass_max[327:264], total_count[374:328], pad
  input  logic [pre_pkg::InDataW-1:0]    s_axis_tdata,
  // command[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // rate[62:0], pad
  output logic [pre_pkg::OutDataW-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [1:0]                     m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pre_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pre_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned Fb   = FRACTION_BITS;
  localparam int unsigned KW   = Fb + 2;
  localparam int unsigned LgW  = Fb + 1;
  localparam int unsigned RoomW = 47 + Fb;
  localparam logic [63:0] One  = 64'd1 << Fb;
  localparam logic [63:0] Two  = 64'd2 << Fb;
  localparam int unsigned Steps = 64;

  // configuration
  logic [31:0] starve_q, death_q, dup_q;
  logic [46:0] cap_q;
  logic [8:0]  count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      starve_q <= '0;
      death_q  <= '0;
      dup_q    <= '0;
      cap_q    <= '0;
      count_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pre_pkg::CFG_STARVE: starve_q <= cfg_data_i[31:0];
        pre_pkg::CFG_DEATH:  death_q  <= cfg_data_i[31:0];
        pre_pkg::CFG_DUP:    dup_q    <= cfg_data_i[31:0];
        pre_pkg::CFG_CAP:    cap_q    <= cfg_data_i;
        pre_pkg::CFG_COUNT:  count_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic o_v_q;
  assign en            = !o_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage a: decode and clamp
  pre_pkg::early_t in_e, a_e_q, b_e_q, c_e_q;
  logic [Fb-1:0] a_t_q;
  logic [63:0]   in_n, in_bm, in_bmin, in_bmax;
  logic [46:0]   in_tot;
  logic [8:0]    limit;
  logic [Fb-1:0] in_t;

  always_comb begin
    in_n    = s_axis_tdata[71:8];
    in_bm   = s_axis_tdata[135] ? 64'd0 : s_axis_tdata[135:72];
    in_bmin = s_axis_tdata[199] ? 64'd0 : s_axis_tdata[199:136];
    in_bmax = s_axis_tdata[327:264];
    in_tot  = s_axis_tdata[374:328];
    limit   = (count_q < pre_pkg::SpeciesMax) ? count_q : pre_pkg::SpeciesMax;
    in_t    = Fb'(in_n - One);
    in_e.cmd   = pre_pkg::cmd_e'(s_axis_tuser);
    in_e.bad   = {1'b0, s_axis_tdata[7:0]} >= limit;
    in_e.alive = !in_n[63] && (in_n > One);
    in_e.ge2   = in_n >= Two;
    in_e.dupok = in_e.alive && !in_bmax[63] && (in_bmax > 64'd1) && (cap_q != '0)
                 && (in_tot < cap_q);
    in_e.n     = in_n;
    in_e.bm    = in_bm;
    in_e.bmean = s_axis_tdata[263] ? 64'd0 : s_axis_tdata[263:200];
    in_e.bmax  = in_bmax;
    in_e.eff   = (in_bm > in_bmin) ? 63'(in_bm - in_bmin) : 63'd0;
    in_e.left  = cap_q - in_tot;
  end

  // ---------------- stages b, c: cubic fade
  logic [2*Fb-1:0] b_tt_q;
  logic [KW-1:0]   b_k_q;
  logic [2*Fb+1:0] c_fp_q;

  // ---------------- stage d: operand select
  logic [63:0]  d_ma_q, d_mb_q, d_dv_q;
  logic [62:0]  d_capa_q;
  logic [46:0]  d_left_q;
  pre_pkg::tag_t d_tag_q;

  logic [63:0]      fade, w, ma, mb, dv;
  logic [62:0]      capa, room;
  logic [RoomW-1:0] room_w;
  logic             room_ovf;
  pre_pkg::tag_t    tag;

  always_comb begin
    fade = !c_e_q.alive ? 64'd0 : (c_e_q.ge2 ? One : 64'(c_fp_q[2*Fb+1:Fb]));
    w    = c_e_q.ge2 ? (c_e_q.n & ~(One - 64'd1)) : fade;
    room_w   = {c_e_q.left, {Fb{1'b0}}};
    room_ovf = |(room_w >> 63);
    room     = room_ovf ? pre_pkg::Max63 : 63'(room_w);
    ma   = w;
    mb   = c_e_q.bm;
    dv   = c_e_q.bmax;
    capa = room;
    tag.cmd  = c_e_q.cmd;
    tag.bad  = c_e_q.bad && (c_e_q.cmd != pre_pkg::CMD_NONE);
    tag.zero = 1'b1;
    tag.sat  = 1'b0;
    tag.nul  = 1'b0;
    unique case (c_e_q.cmd)
      pre_pkg::CMD_STARVE: begin
        ma       = {1'b0, c_e_q.eff};
        mb       = fade;
        dv       = One;
        capa     = 63'd1;
        tag.zero = c_e_q.bad;
      end
      pre_pkg::CMD_DEATH: begin
        mb       = c_e_q.bmean;
        dv       = c_e_q.bm;
        capa     = c_e_q.n[62:0];
        tag.zero = c_e_q.bad || !c_e_q.alive || (c_e_q.bm == 64'd0);
      end
      pre_pkg::CMD_DUP: begin
        tag.zero = c_e_q.bad || !c_e_q.dupok;
        tag.sat  = !tag.zero && room_ovf;
      end
      default: tag.zero = 1'b1;
    endcase
  end

  // ---------------- stages e, f: 64x64 product
  logic [63:0]  e_ll_q, e_lh_q, e_hl_q, e_hh_q, e_dv_q;
  logic [62:0]  e_capa_q;
  logic [46:0]  e_left_q;
  pre_pkg::tag_t e_tag_q;
  logic [127:0] f_p_q;
  logic [63:0]  f_dv_q;
  logic [62:0]  f_capa_q;
  logic [46:0]  f_left_q;
  pre_pkg::tag_t f_tag_q;

  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, f_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_e_q    <= in_e;
      a_t_q    <= in_t;
      b_e_q    <= a_e_q;
      b_tt_q   <= (2*Fb)'(a_t_q) * (2*Fb)'(a_t_q);
      b_k_q    <= (KW'(3) << Fb) - KW'({a_t_q, 1'b0});
      c_e_q    <= b_e_q;
      c_fp_q   <= (2*Fb+2)'(b_tt_q[2*Fb-1:Fb]) * (2*Fb+2)'(b_k_q);
      d_ma_q   <= ma;
      d_mb_q   <= mb;
      d_dv_q   <= dv;
      d_capa_q <= capa;
      d_left_q <= c_e_q.left;
      d_tag_q  <= tag;
      e_ll_q   <= d_ma_q[31:0]  * d_mb_q[31:0];
      e_lh_q   <= d_ma_q[31:0]  * d_mb_q[63:32];
      e_hl_q   <= d_ma_q[63:32] * d_mb_q[31:0];
      e_hh_q   <= d_ma_q[63:32] * d_mb_q[63:32];
      e_dv_q   <= d_dv_q;
      e_capa_q <= d_capa_q;
      e_left_q <= d_left_q;
      e_tag_q  <= d_tag_q;
      f_p_q    <= {64'd0, e_ll_q} + {32'd0, e_lh_q, 32'd0} + {32'd0, e_hl_q, 32'd0}
                  + {e_hh_q, 64'd0};
      f_dv_q   <= e_dv_q;
      f_capa_q <= e_capa_q;
      f_left_q <= e_left_q;
      f_tag_q  <= e_tag_q;
    end
  end

  // ---------------- first divider: w*num/den, and (K-N)<<F / K in the first F steps
  logic           q1_v_q    [0:Steps];
  logic [63:0]    q1_rem_q  [0:Steps];
  logic [63:0]    q1_lo_q   [0:Steps];
  logic [63:0]    q1_dv_q   [0:Steps];
  logic           q1_ovf_q  [0:Steps];
  logic [62:0]    q1_capa_q [0:Steps];
  logic [46:0]    q1_lrem_q [0:Steps];
  logic [LgW-1:0] q1_lq_q   [0:Steps];
  pre_pkg::tag_t  q1_tag_q  [0:Steps];
  logic           lg_top;

  // integer part of the room fraction: one when nothing is taken yet
  assign lg_top = f_left_q >= cap_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_rem_q[0]  <= f_p_q[127:64];
      q1_lo_q[0]   <= f_p_q[63:0];
      q1_dv_q[0]   <= f_dv_q;
      q1_ovf_q[0]  <= f_p_q[127:64] >= f_dv_q;
      q1_capa_q[0] <= f_capa_q;
      q1_lrem_q[0] <= lg_top ? (f_left_q - cap_q) : f_left_q;
      q1_lq_q[0]   <= LgW'(lg_top);
      q1_tag_q[0]  <= f_tag_q;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div1
    logic [64:0] rn, df;
    logic        ge;
    always_comb begin
      rn = {q1_rem_q[k], q1_lo_q[k][63]};
      ge = rn >= {1'b0, q1_dv_q[k]};
      df = rn - {1'b0, q1_dv_q[k]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        q1_v_q[k+1] <= 1'b0;
      end else if (en) begin
        q1_v_q[k+1] <= q1_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        q1_rem_q[k+1]  <= ge ? df[63:0] : rn[63:0];
        q1_lo_q[k+1]   <= {q1_lo_q[k][62:0], ge};
        q1_dv_q[k+1]   <= q1_dv_q[k];
        q1_ovf_q[k+1]  <= q1_ovf_q[k];
        q1_capa_q[k+1] <= q1_capa_q[k];
        q1_tag_q[k+1]  <= q1_tag_q[k];
      end
    end
    if (k < Fb) begin : g_lg
      logic [47:0] lrn, ldf;
      logic        lge;
      always_comb begin
        lrn = {q1_lrem_q[k], 1'b0};
        lge = lrn >= {1'b0, cap_q};
        ldf = lrn - {1'b0, cap_q};
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          q1_lrem_q[k+1] <= lge ? ldf[46:0] : lrn[46:0];
          q1_lq_q[k+1]   <= {q1_lq_q[k][LgW-2:0], lge};
        end
      end
    end else begin : g_lp
      always_ff @(posedge clk_i) begin
        if (en) begin
          q1_lrem_q[k+1] <= q1_lrem_q[k];
          q1_lq_q[k+1]   <= q1_lq_q[k];
        end
      end
    end
  end

  // ---------------- stages h..k: times room fraction, times gain
  logic          x_ovf;
  logic [62:0]   x1;
  logic [LgW-1:0] lg;
  pre_pkg::tag_t h_tag;

  always_comb begin
    x_ovf = q1_ovf_q[Steps] || q1_lo_q[Steps][63];
    x1    = x_ovf ? pre_pkg::Max63 : q1_lo_q[Steps][62:0];
    lg    = (q1_tag_q[Steps].cmd == pre_pkg::CMD_DUP) ? q1_lq_q[Steps]
                                                      : One[LgW-1:0];
    h_tag = q1_tag_q[Steps];
    // death and duplication saturate here; starvation cannot overflow
    h_tag.sat = q1_tag_q[Steps].sat || (x_ovf && !q1_tag_q[Steps].zero);
  end

  logic [32+LgW-1:0] h_pl_q;
  logic [31+LgW-1:0] h_ph_q;
  logic [62:0]       h_capa_q, i_x2_q, i_capa_q, j_capa_q, k_x3_q, k_capa_q;
  pre_pkg::tag_t     h_tag_q, i_tag_q, j_tag_q, k_tag_q;
  logic [63:0]       j_pl_q;
  logic [62:0]       j_ph_q;
  logic h_v_q, i_v_q, j_v_q, k_v_q, l_v_q;

  logic [63+LgW-1:0] xl_prod;
  logic [31:0]       gain;
  logic [94:0]       xg_prod;
  logic [78:0]       xg_sh;
  logic              xg_ovf;
  pre_pkg::tag_t     k_tag;

  always_comb begin
    xl_prod = {h_ph_q, 32'd0} + (63+LgW)'(h_pl_q);
    unique case (i_tag_q.cmd)
      pre_pkg::CMD_STARVE: gain = starve_q;
      pre_pkg::CMD_DEATH:  gain = death_q;
      pre_pkg::CMD_DUP:    gain = dup_q;
      default:             gain = '0;
    endcase
    xg_prod = {j_ph_q, 32'd0} + 95'(j_pl_q);
    xg_sh   = xg_prod[94:pre_pkg::GainBits];
    xg_ovf  = |xg_sh[78:63];
    k_tag   = j_tag_q;
    k_tag.sat = j_tag_q.sat || (xg_ovf && !j_tag_q.zero);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_pl_q   <= (32+LgW)'(x1[31:0]) * (32+LgW)'(lg);
      h_ph_q   <= (31+LgW)'(x1[62:32]) * (31+LgW)'(lg);
      h_capa_q <= q1_capa_q[Steps];
      h_tag_q  <= h_tag;
      i_x2_q   <= 63'(xl_prod >> Fb);
      i_capa_q <= h_capa_q;
      i_tag_q  <= h_tag_q;
      j_pl_q   <= i_x2_q[31:0] * gain;
      j_ph_q   <= 63'(i_x2_q[62:32]) * 63'(gain);
      j_capa_q <= i_capa_q;
      j_tag_q  <= i_tag_q;
      k_x3_q   <= xg_ovf ? pre_pkg::Max63 : xg_sh[62:0];
      k_capa_q <= j_capa_q;
      k_tag_q  <= k_tag;
    end
  end

  // ---------------- stage l: soft cap product and divisor
  logic [63:0]   l_ll_q, l_lh_q, l_hl_q, l_hh_q, l_dv_q;
  pre_pkg::tag_t l_tag_q, l_tag;
  logic [63:0]   sc_dv;

  always_comb begin
    l_tag     = k_tag_q;
    l_tag.nul = (k_x3_q == '0) || (k_capa_q == '0);
    // starvation passes through as x*1/1
    sc_dv     = (k_tag_q.cmd == pre_pkg::CMD_STARVE) ? 64'd1
                : 64'(k_x3_q) + 64'(k_capa_q) + 64'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_ll_q  <= k_x3_q[31:0] * k_capa_q[31:0];
      l_lh_q  <= 64'(k_x3_q[31:0]) * 64'(k_capa_q[62:32]);
      l_hl_q  <= 64'(k_x3_q[62:32]) * 64'(k_capa_q[31:0]);
      l_hh_q  <= 64'(k_x3_q[62:32]) * 64'(k_capa_q[62:32]);
      l_dv_q  <= sc_dv;
      l_tag_q <= l_tag;
    end
  end

  // ---------------- second divider: soft cap
  logic          q2_v_q   [0:Steps];
  logic [63:0]   q2_rem_q [0:Steps];
  logic [63:0]   q2_lo_q  [0:Steps];
  logic [63:0]   q2_dv_q  [0:Steps];
  pre_pkg::tag_t q2_tag_q [0:Steps];
  logic [127:0]  sc_p;

  assign sc_p = {64'd0, l_ll_q} + {32'd0, l_lh_q, 32'd0} + {32'd0, l_hl_q, 32'd0}
                + {l_hh_q, 64'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      q2_rem_q[0] <= sc_p[127:64];
      q2_lo_q[0]  <= sc_p[63:0];
      q2_dv_q[0]  <= l_dv_q;
      q2_tag_q[0] <= l_tag_q;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div2
    logic [64:0] rn, df;
    logic        ge;
    always_comb begin
      rn = {q2_rem_q[k], q2_lo_q[k][63]};
      ge = rn >= {1'b0, q2_dv_q[k]};
      df = rn - {1'b0, q2_dv_q[k]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        q2_v_q[k+1] <= 1'b0;
      end else if (en) begin
        q2_v_q[k+1] <= q2_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        q2_rem_q[k+1] <= ge ? df[63:0] : rn[63:0];
        q2_lo_q[k+1]  <= {q2_lo_q[k][62:0], ge};
        q2_dv_q[k+1]  <= q2_dv_q[k];
        q2_tag_q[k+1] <= q2_tag_q[k];
      end
    end
  end

  // ---------------- output register
  logic [62:0]        o_rate_q;
  pre_pkg::status_e   o_st_q, o_st;
  pre_pkg::tag_t      t_end;

  always_comb begin
    t_end = q2_tag_q[Steps];
    if (t_end.bad) begin
      o_st = pre_pkg::ST_BAD;
    end else if (t_end.sat) begin
      o_st = pre_pkg::ST_SAT;
    end else begin
      o_st = pre_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_rate_q <= (t_end.zero || t_end.nul) ? 63'd0 : q2_lo_q[Steps][62:0];
      o_st_q   <= o_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      d_v_q     <= 1'b0;
      e_v_q     <= 1'b0;
      f_v_q     <= 1'b0;
      q1_v_q[0] <= 1'b0;
      h_v_q     <= 1'b0;
      i_v_q     <= 1'b0;
      j_v_q     <= 1'b0;
      k_v_q     <= 1'b0;
      l_v_q     <= 1'b0;
      q2_v_q[0] <= 1'b0;
      o_v_q     <= 1'b0;
    end else if (en) begin
      a_v_q     <= s_axis_tvalid;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q;
      d_v_q     <= c_v_q;
      e_v_q     <= d_v_q;
      f_v_q     <= e_v_q;
      q1_v_q[0] <= f_v_q;
      h_v_q     <= q1_v_q[Steps];
      i_v_q     <= h_v_q;
      j_v_q     <= i_v_q;
      k_v_q     <= j_v_q;
      l_v_q     <= k_v_q;
      q2_v_q[0] <= l_v_q;
      o_v_q     <= q2_v_q[Steps];
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {1'b0, o_rate_q};
  assign m_axis_tuser  = o_st_q;

  // an item forced to zero never carries a saturation mark
  a_zero_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q1_v_q[Steps] && q1_tag_q[Steps].zero |-> !q1_tag_q[Steps].sat)
    else $error("zeroed item marked saturated");

  // soft cap quotient must fit: high product half below the divisor
  a_sc_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q2_v_q[0] && !q2_tag_q[0].zero && !q2_tag_q[0].nul
    |-> q2_rem_q[0] < q2_dv_q[0])
    else $error("soft cap quotient overflow");

  // a rejected species yields a zero rate
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pre_pkg::ST_BAD) |-> m_axis_tdata == '0)
    else $error("invalid species with nonzero rate");

endmodule
